@@ rtl/pps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int TIME_W    = 16;
  localparam int PRIO_W    = 8;
  localparam int SLOT_W    = 6;
  localparam int COUNT_W   = 7;
  localparam int SUM_W     = 32;
  localparam int NZ_W      = 2;

  localparam int DEFAULT_MAX_TASKS = 64;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [SLOT_W-1:0] entry_index;
    logic [TIME_W-1:0] arrive_tick;
    logic [PRIO_W-1:0] priority_req;
    logic [TIME_W-1:0] burst_length;
  } in_t;

  typedef struct packed {
    logic [TIME_W-1:0] tick_time;
    logic              idle;
    logic [SLOT_W-1:0] running_index;
    logic              finished;
    logic [TIME_W-1:0] turnaround;
    logic [SUM_W-1:0]  turnaround_sum;
    logic              all_done;
  } out_t;

  // Broadcast strobes from the sequencer to every cell
  typedef struct packed {
    logic wr;
    logic dec;
  } cell_ctrl_t;

  // Running summary handed from cell to cell along the chain
  typedef struct packed {
    logic              have;
    logic [PRIO_W-1:0] best_prio;
    logic [TIME_W-1:0] best_arr;
    logic [TIME_W-1:0] best_rem;
    logic              cur_ready;
    logic [PRIO_W-1:0] cur_prio;
    logic [TIME_W-1:0] cur_arr;
    logic [TIME_W-1:0] cur_rem;
    logic [NZ_W-1:0]   nz;
  } token_t;

endpackage

@@ rtl/preemptive_priority_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Preemptive priority task scheduler built as a chain of task-slot cells.
// ----------------------------------------------------------------------------
//  channel  | signals                 | direction | handshake
//  ---------+-------------------------+-----------+---------------------------
//  command  | start, busy, item       | in        | transfer on start && !busy
//  result   | done, result            | out       | one-cycle strobe, no stall
//  config   | cfg_wr, cfg_wdata       | in        | write on cfg_wr
//
//  Each item (load or tick) keeps busy high while the summary token ripples
//  through the slot chain in the scan state and while the decide state then
//  picks the task and updates state. done pulses in the cycle
//  after, when a new item may already be taken. A load writes its slot at
//  the accepting edge. Reset (rst, synchronous) clears control state only;
//  slot tables hold garbage until loaded. The receiver cannot stall.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
  parameter int MAX_TASKS = pps_pkg::DEFAULT_MAX_TASKS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  pps_pkg::in_t                item,
  output logic                        done,
  output pps_pkg::out_t               result,
  input  logic                        cfg_wr,
  input  logic [pps_pkg::COUNT_W-1:0] cfg_wdata
);

  localparam int IB    = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int AW    = (CNT_W > pps_pkg::COUNT_W) ? CNT_W : pps_pkg::COUNT_W;
  localparam int TW    = pps_pkg::TIME_W;
  localparam int SW    = pps_pkg::SUM_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  logic [IB-1:0]               cnt;
  logic                        cmd_op;
  logic [TW-1:0]               now;
  logic [IB-1:0]               cur_task;
  logic                        cur_valid;
  logic [SW-1:0]               sum;
  logic [pps_pkg::COUNT_W-1:0] pcount;

  logic                        accept;
  logic [AW-1:0]               pc_ext;
  logic [CNT_W-1:0]            n_active;
  pps_pkg::cell_ctrl_t         ctrl;

  pps_pkg::token_t             tok   [MAX_TASKS+1];
  logic [IB-1:0]               idx   [MAX_TASKS+1];

  pps_pkg::token_t             f;
  logic                        is_tick;
  logic                        cur_ok;
  logic                        use_best;
  logic                        ran;
  logic [IB-1:0]               run_idx;
  logic [TW-1:0]               run_arr;
  logic [TW-1:0]               run_rem;
  logic [TW-1:0]               rem_dec;
  logic                        fin;
  logic [TW:0]                 tat_wide;
  logic [TW-1:0]               tat;
  logic [SW:0]                 sum_wide;
  logic [SW-1:0]               sum_next;
  logic                        all_done;
  pps_pkg::out_t               result_next;

  assign busy   = state != S_IDLE;
  assign accept = start && !busy;

  // Clamp the configured count to the number of slots
  always_comb begin
    pc_ext   = AW'(pcount);
    n_active = (pc_ext > AW'(MAX_TASKS)) ? CNT_W'(MAX_TASKS) : CNT_W'(pc_ext);
  end

  // Sequencer state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_SCAN;
      S_SCAN:   if (cnt == IB'(MAX_TASKS - 1)) state_next = S_DECIDE;
      S_DECIDE: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state == S_SCAN) ? cnt + IB'(1) : '0;
    end
  end

  // Hold the opcode of the accepted item
  always_ff @(posedge clk) begin
    if (accept) cmd_op <= item.opcode;
  end

  // Cell broadcasts
  always_comb begin
    ctrl.wr  = accept && (item.opcode == pps_pkg::OP_LOAD);
    ctrl.dec = (state == S_DECIDE) && is_tick && ran;
  end

  // Slot chain
  assign tok[0] = '0;
  assign idx[0] = '0;

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    pps_cell #(
      .MAX_TASKS (MAX_TASKS),
      .INDEX     (g)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .wr_data  (item),
      .dec_idx  (run_idx),
      .cur_idx  (cur_task),
      .now      (now),
      .n_active (n_active),
      .tok_in   (tok[g]),
      .idx_in   (idx[g]),
      .tok_out  (tok[g+1]),
      .idx_out  (idx[g+1])
    );
  end

  // Pick the task to run from the chain summary
  always_comb begin
    f        = tok[MAX_TASKS];
    is_tick  = cmd_op == pps_pkg::OP_TICK;
    cur_ok   = cur_valid && f.cur_ready;
    use_best = f.have && (!cur_ok || (f.best_prio < f.cur_prio));
    ran      = cur_ok || f.have;
    run_idx  = use_best ? idx[MAX_TASKS] : cur_task;
    run_arr  = use_best ? f.best_arr : f.cur_arr;
    run_rem  = use_best ? f.best_rem : f.cur_rem;
    rem_dec  = run_rem - TW'(1);
    fin      = is_tick && ran && (rem_dec == '0);
    tat_wide = {1'b0, now} + (TW+1)'(1) - {1'b0, run_arr};
    tat      = tat_wide[TW] ? '1 : tat_wide[TW-1:0];
    sum_wide = {1'b0, sum} + (SW+1)'(tat);
    sum_next = sum_wide[SW] ? '1 : sum_wide[SW-1:0];

    // The finishing task leaves one fewer slot with work
    if (fin)
      all_done = f.nz == pps_pkg::NZ_W'(1);
    else if (is_tick && ran)
      all_done = 1'b0;
    else
      all_done = f.nz == '0;

    result_next                = '0;
    result_next.tick_time      = now;
    result_next.idle           = !(is_tick && ran);
    result_next.running_index  = (is_tick && ran) ? pps_pkg::SLOT_W'(run_idx) : '0;
    result_next.finished       = fin;
    result_next.turnaround     = fin ? tat : '0;
    result_next.turnaround_sum = fin ? sum_next : sum;
    result_next.all_done       = all_done;
  end

  // Advance time and the running task on each tick
  always_ff @(posedge clk) begin
    if (rst) begin
      now       <= '0;
      cur_task  <= '0;
      cur_valid <= 1'b0;
      sum       <= '0;
    end else if ((state == S_DECIDE) && is_tick) begin
      now       <= now + TW'(1);
      cur_valid <= ran && !fin;
      if (ran) cur_task <= run_idx;
      if (fin) sum <= sum_next;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      pcount <= pps_pkg::COUNT_W'(1);
    end else if (cfg_wr) begin
      pcount <= cfg_wdata;
    end
  end

  // Result strobe and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= state == S_DECIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DECIDE) result <= result_next;
  end

  // Checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an item in work");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_fin_not_idle: assert property (@(posedge clk) disable iff (rst)
    (done && result.finished) |-> !result.idle)
    else $error("completion reported on an idle result");

endmodule

@@ rtl/pps_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_cell
// One task slot: holds its arrival, priority and remaining work, and folds
// itself into the summary token passed on to the next cell each cycle.
// ----------------------------------------------------------------------------
module pps_cell #(
  parameter int MAX_TASKS = pps_pkg::DEFAULT_MAX_TASKS,
  parameter int INDEX     = 0,
  localparam int IB       = $clog2(MAX_TASKS),
  localparam int CNT_W    = $clog2(MAX_TASKS + 1)
) (
  input  logic                       clk,
  input  pps_pkg::cell_ctrl_t        ctrl,
  input  pps_pkg::in_t               wr_data,
  input  logic [IB-1:0]              dec_idx,
  input  logic [IB-1:0]              cur_idx,
  input  logic [pps_pkg::TIME_W-1:0] now,
  input  logic [CNT_W-1:0]           n_active,
  input  pps_pkg::token_t            tok_in,
  input  logic [IB-1:0]              idx_in,
  output pps_pkg::token_t            tok_out,
  output logic [IB-1:0]              idx_out
);

  logic [pps_pkg::TIME_W-1:0] arrival;
  logic [pps_pkg::PRIO_W-1:0] prio;
  logic [pps_pkg::TIME_W-1:0] remaining;

  logic            active;
  logic            ready;
  logic            take;
  pps_pkg::token_t tok_next;

  // Write on load, count down when chosen to run
  always_ff @(posedge clk) begin
    if (ctrl.wr && (int'(wr_data.entry_index) == INDEX)) begin
      arrival   <= wr_data.arrive_tick;
      prio      <= wr_data.priority_req;
      remaining <= wr_data.burst_length;
    end else if (ctrl.dec && (dec_idx == IB'(INDEX))) begin
      remaining <= remaining - pps_pkg::TIME_W'(1);
    end
  end

  // Fold this slot into the summary
  always_comb begin
    active   = INDEX < int'(n_active);
    ready    = active && (arrival <= now) && (remaining != '0);
    take     = ready && (!tok_in.have || (prio < tok_in.best_prio));
    tok_next = tok_in;
    if (take) begin
      tok_next.have      = 1'b1;
      tok_next.best_prio = prio;
      tok_next.best_arr  = arrival;
      tok_next.best_rem  = remaining;
    end
    if (cur_idx == IB'(INDEX)) begin
      tok_next.cur_ready = ready;
      tok_next.cur_prio  = prio;
      tok_next.cur_arr   = arrival;
      tok_next.cur_rem   = remaining;
    end
    if (active && (remaining != '0) && (tok_in.nz != '1)) begin
      tok_next.nz = tok_in.nz + pps_pkg::NZ_W'(1);
    end
  end

  // Hand the summary to the neighbor
  always_ff @(posedge clk) begin
    tok_out <= tok_next;
    idx_out <= take ? IB'(INDEX) : idx_in;
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the preemptive priority scheduler. A scoreboard
// keeps its own copy of the task tables and scheduling state, predicts the
// report for every accepted load or tick, and compares each report strobe
// field by field. A short directed sequence comes first: tie holding,
// preemption, reload of the running slot, zero burst and idle ticks. Random
// bursts with random gaps then run across several task-count settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SLOTS       = pps_pkg::DEFAULT_MAX_TASKS;
  localparam int ITEM_CYCLES = SLOTS + 2;
  localparam int CYCLE_LIMIT = 600000;

  // Predicts the scheduler report of each transfer and holds it until it is seen
  class sched_scoreboard;
    bit [pps_pkg::TIME_W-1:0]  arrival_tbl [SLOTS];
    bit [pps_pkg::PRIO_W-1:0]  prio_tbl    [SLOTS];
    bit [pps_pkg::TIME_W-1:0]  remain_tbl  [SLOTS];
    bit [pps_pkg::SLOT_W-1:0]  cur_task;
    bit                        cur_valid;
    bit [pps_pkg::TIME_W-1:0]  now_tick;
    bit [pps_pkg::SUM_W-1:0]   tat_sum;
    bit [pps_pkg::COUNT_W-1:0] task_count;
    pps_pkg::out_t             expected_reports [$];
    int                        errors;
    int                        loads;
    int                        ticks;
    int                        completions;
    int                        settings;

    function new();
      cur_task   = '0;
      cur_valid  = 1'b0;
      now_tick   = '0;
      tat_sum    = '0;
      task_count = pps_pkg::COUNT_W'(1);
    endfunction

    function void set_count(input bit [pps_pkg::COUNT_W-1:0] value);
      task_count = value;
      settings++;
    endfunction

    function int active_slots();
      return (task_count > SLOTS) ? SLOTS : int'(task_count);
    endfunction

    function bit slot_ready(input int slot);
      if (slot >= active_slots()) return 1'b0;
      return (arrival_tbl[slot] <= now_tick) && (remain_tbl[slot] != '0);
    endfunction

    function bit all_retired();
      int i;
      for (i = 0; i < active_slots(); i++)
        if (remain_tbl[i] != '0) return 1'b0;
      return 1'b1;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    // Apply one transfer to the state and queue the report it must produce
    function void note_item(input pps_pkg::in_t it);
      pps_pkg::out_t rep;
      int            i;
      int            best;
      bit            have;
      int            run;
      int            tat;
      longint        wide_sum;
      rep = '0;
      rep.tick_time = now_tick;
      rep.idle = 1'b1;
      if (it.opcode == pps_pkg::OP_LOAD) begin
        arrival_tbl[it.entry_index] = it.arrive_tick;
        prio_tbl[it.entry_index]    = it.priority_req;
        remain_tbl[it.entry_index]  = it.burst_length;
        loads++;
      end else begin
        ticks++;
        have = 1'b0;
        best = 0;
        // pick the best ready slot, lowest index on a tie
        for (i = 0; i < active_slots(); i++) begin
          if (slot_ready(i) && (!have || prio_tbl[i] < prio_tbl[best])) begin
            best = i;
            have = 1'b1;
          end
        end
        run = -1;
        // hold the running task unless something strictly better is ready
        if (cur_valid && slot_ready(int'(cur_task))) begin
          run = int'(cur_task);
          if (have && prio_tbl[best] < prio_tbl[run]) run = best;
        end else if (have) begin
          run = best;
        end
        if (run < 0) begin
          cur_valid = 1'b0;
        end else begin
          remain_tbl[run] = remain_tbl[run] - 1'b1;
          rep.idle = 1'b0;
          rep.running_index = pps_pkg::SLOT_W'(run);
          if (remain_tbl[run] == '0) begin
            tat = int'(now_tick) + 1 - int'(arrival_tbl[run]);
            if (tat > 65535) tat = 65535;
            wide_sum = longint'(tat_sum) + tat;
            tat_sum = (wide_sum > 64'hFFFF_FFFF) ? '1 : pps_pkg::SUM_W'(wide_sum);
            rep.finished = 1'b1;
            rep.turnaround = pps_pkg::TIME_W'(tat);
            cur_valid = 1'b0;
            completions++;
          end else begin
            cur_valid = 1'b1;
          end
          cur_task = pps_pkg::SLOT_W'(run);
        end
        now_tick = now_tick + 1'b1;
      end
      rep.turnaround_sum = tat_sum;
      rep.all_done = all_retired();
      expected_reports.push_back(rep);
    endfunction

    function void match_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Compare one report strobe with the oldest prediction
    function void check_report(input pps_pkg::out_t got);
      pps_pkg::out_t want;
      if (expected_reports.size() == 0) begin
        $error("report strobe with no transfer outstanding");
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      match_field("tick_time", want.tick_time, got.tick_time);
      match_field("idle", want.idle, got.idle);
      match_field("running_index", want.running_index, got.running_index);
      match_field("finished", want.finished, got.finished);
      match_field("turnaround", want.turnaround, got.turnaround);
      match_field("turnaround_sum", want.turnaround_sum, got.turnaround_sum);
      match_field("all_done", want.all_done, got.all_done);
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  pps_pkg::in_t                item = '0;
  logic                        done;
  pps_pkg::out_t               result;
  logic                        cfg_wr = 1'b0;
  logic [pps_pkg::COUNT_W-1:0] cfg_wdata = '0;
  int                          cycles = 0;

  sched_scoreboard sb = new();

  preemptive_priority_scheduler #(
    .MAX_TASKS(SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .done     (done),
    .result   (result),
    .cfg_wr   (cfg_wr),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Give up on a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Check reports first, then note a command transfer at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_report(result);
      if (start && busy === 1'b0) sb.note_item(item);
    end
  end

  function automatic pps_pkg::in_t load_entry(input int slot, input int arr,
                                              input int prio, input int burst);
    pps_pkg::in_t it;
    it = '0;
    it.opcode       = pps_pkg::OP_LOAD;
    it.entry_index  = pps_pkg::SLOT_W'(slot);
    it.arrive_tick  = pps_pkg::TIME_W'(arr);
    it.priority_req = pps_pkg::PRIO_W'(prio);
    it.burst_length = pps_pkg::TIME_W'(burst);
    return it;
  endfunction

  function automatic pps_pkg::in_t tick_item();
    pps_pkg::in_t it;
    it = '0;
    it.opcode = pps_pkg::OP_TICK;
    return it;
  endfunction

  // Random item: arrivals near the current tick, small priorities for ties,
  // short bursts so tasks finish, with rare full-range values
  function automatic pps_pkg::in_t make_item(input int slots);
    pps_pkg::in_t it;
    logic [63:0]  raw;
    int           now_val;
    int           pick;
    raw = {$urandom, $urandom};
    it = raw[$bits(pps_pkg::in_t)-1:0];
    now_val = int'(sb.now_tick);
    it.opcode = ($urandom_range(0, 99) < 62) ? pps_pkg::OP_TICK : pps_pkg::OP_LOAD;
    if (slots > 0 && $urandom_range(0, 4) != 0)
      it.entry_index = pps_pkg::SLOT_W'($urandom_range(0, slots - 1));
    pick = $urandom_range(0, 15);
    if (pick >= 4)
      it.arrive_tick = pps_pkg::TIME_W'(
        now_val - $urandom_range(0, (now_val < 12) ? now_val : 12));
    else if (pick >= 1)
      it.arrive_tick = pps_pkg::TIME_W'(now_val + $urandom_range(1, 24));
    if ($urandom_range(0, 15) < 10)
      it.priority_req = pps_pkg::PRIO_W'($urandom_range(0, 7));
    pick = $urandom_range(0, 23);
    if (pick == 0)
      it.burst_length = '0;
    else if (pick != 1)
      it.burst_length = pps_pkg::TIME_W'($urandom_range(1, 6));
    return it;
  endfunction

  // Present one item and hold it until the transfer edge
  task automatic send_item(input pps_pkg::in_t it);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Drop start and wait until every predicted report has been seen
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_count(input int value);
    cfg_wr    <= 1'b1;
    cfg_wdata <= pps_pkg::COUNT_W'(value);
    @(posedge clk);
    cfg_wr <= 1'b0;
    sb.set_count(pps_pkg::COUNT_W'(value));
  endtask

  // Send random items in bursts separated by random gaps
  task automatic send_random(input int count, input int slots);
    int k;
    int burst_left;
    burst_left = 0;
    for (k = 0; k < count; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        if ($urandom_range(0, 3) != 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 80)) @(posedge clk);
        end
      end
      send_item(make_item(slots));
      burst_left--;
    end
  endtask

  initial begin
    int           phase_counts [10];
    int           p;
    int           k;
    pps_pkg::in_t it;
    phase_counts = '{64, 1, 127, 2, 65, 0, 64, 8, 0, 33};
    phase_counts[5] = $urandom_range(3, 20);
    phase_counts[8] = $urandom_range(1, 64);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // No slot takes part while the task count is zero
    write_count(0);
    send_item(tick_item());
    send_item(load_entry(63, 65535, 255, 65535));
    send_item(load_entry(0, 2, 20, 3));
    send_item(load_entry(1, 0, 20, 4));
    send_item(load_entry(2, 4, 5, 2));
    send_item(load_entry(3, 0, 0, 0));
    drain();
    write_count(4);
    // slot 1 runs alone, then holds the processor when slot 0 ties it
    send_item(tick_item());
    send_item(tick_item());
    // reload the running slot, then let slot 2 preempt and finish
    send_item(load_entry(1, 0, 20, 3));
    send_item(tick_item());
    send_item(tick_item());
    send_item(tick_item());
    // tie after a finish goes to slot 0; zeroing its burst forces a new pick
    send_item(tick_item());
    send_item(load_entry(0, 2, 20, 0));
    send_item(tick_item());
    send_item(tick_item());
    send_item(tick_item());

    // Load every slot so any task count is safe
    for (k = 0; k < SLOTS; k++) begin
      it = make_item(SLOTS);
      it.opcode = pps_pkg::OP_LOAD;
      it.entry_index = pps_pkg::SLOT_W'(k);
      send_item(it);
    end

    for (p = 0; p < 10; p++) begin
      drain();
      write_count(phase_counts[p]);
      send_random(62, (phase_counts[p] > SLOTS) ? SLOTS : phase_counts[p]);
    end

    drain();
    repeat (3 * ITEM_CYCLES) @(posedge clk);
    $display("Covered %0d loads and %0d ticks with %0d task completions,",
             sb.loads, sb.ticks, sb.completions);
    $display("over %0d task-count settings including 0, 1, 64 and 127.", sb.settings);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
